@@ rtl/pat_pkg.sv @@
// ----------------------------------------------------------------------------
// pat_pkg
// Types and constants shared by the paged address translator modules.
// ----------------------------------------------------------------------------
package pat_pkg;

  localparam int ADDR_W      = 18;
  localparam int PC_W        = 7;
  localparam int FC_W        = 6;
  localparam int PB_W        = 13;
  localparam int IDX_W       = 12;
  localparam int OFF_W       = 12;
  localparam int FRAME_OUT_W = 5;
  localparam int PHYS_W      = 17;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;

  localparam logic [CFG_IDX_W-1:0] REG_PAGE_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_BYTES  = 2'd2;

  localparam logic OP_TRANSLATE = 1'b0;
  localparam logic OP_ALLOCATE  = 1'b1;

  typedef enum logic [1:0] {
    ST_HIT     = 2'd0,
    ST_FAULT   = 2'd1,
    ST_INVALID = 2'd2,
    ST_ALLOC   = 2'd3
  } status_t;

  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] virt_addr;
  } pat_req_t;

  typedef struct packed {
    status_t                status;
    logic [IDX_W-1:0]       page_index;
    logic [OFF_W-1:0]       page_offset;
    logic [FRAME_OUT_W-1:0] frame_no;
    logic [PHYS_W-1:0]      phys_addr;
  } pat_res_t;

  // effective (clamped) configuration
  typedef struct packed {
    logic [PC_W-1:0] page_count;
    logic [FC_W-1:0] frame_count;
    logic [PB_W-1:0] page_bytes;
  } pat_cfg_t;

  // classified request handed from front to back
  typedef struct packed {
    logic             alloc;
    logic             invalid;
    logic [IDX_W-1:0] page_index;
    logic [PB_W-1:0]  page_offset;
    logic [FC_W-1:0]  victim;
  } pat_cmd_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_MOD,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_LOOK,
    B_MUL
  } back_state_t;

endpackage

@@ rtl/pat_front.sv @@
// ----------------------------------------------------------------------------
// pat_front
// Accepts requests, splits the address into page and offset with a two bit
// per cycle divider, range checks the page and works out its home frame.
// ----------------------------------------------------------------------------
module pat_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  pat_pkg::pat_req_t request,
  input  pat_pkg::pat_cfg_t cfg,
  output logic             cmd_push,
  output pat_pkg::pat_cmd_t cmd,
  input  logic             cmd_full
);
  import pat_pkg::*;

  localparam int DIV_STEPS  = 2;
  localparam int DIV_CYCLES = ADDR_W / DIV_STEPS;
  localparam int CNT_W      = $clog2(ADDR_W + 1);

  front_state_t      state, state_next;
  logic [ADDR_W-1:0] quo;
  logic [PB_W-1:0]   rem;
  logic [PC_W-1:0]   mod_q;
  logic [FC_W-1:0]   mod_rem;
  logic [CNT_W-1:0]  cnt;

  logic [ADDR_W-1:0] q_w;
  logic [PB_W-1:0]   r_w;
  logic [PB_W:0]     trial;
  logic [FC_W:0]     m_trial;
  logic [PC_W-1:0]   mq_w;
  logic [FC_W-1:0]   mr_w;
  logic              invalid_w;
  logic              last;

  // restoring divide, two quotient bits a cycle
  always_comb begin
    q_w   = quo;
    r_w   = rem;
    trial = '0;
    for (int s = 0; s < DIV_STEPS; s++) begin
      trial = {r_w, q_w[ADDR_W-1]};
      q_w   = {q_w[ADDR_W-2:0], 1'b0};
      if (trial >= {1'b0, cfg.page_bytes}) begin
        trial  = trial - {1'b0, cfg.page_bytes};
        q_w[0] = 1'b1;
      end
      r_w = trial[PB_W-1:0];
    end
    invalid_w = q_w >= ADDR_W'(cfg.page_count);
  end

  // page mod frame count, one bit a cycle
  always_comb begin
    m_trial = {mod_rem, mod_q[PC_W-1]};
    mq_w    = {mod_q[PC_W-2:0], 1'b0};
    if (m_trial >= {1'b0, cfg.frame_count}) begin
      m_trial = m_trial - {1'b0, cfg.frame_count};
      mq_w[0] = 1'b1;
    end
    mr_w = m_trial[FC_W-1:0];
  end

  assign last     = cnt == CNT_W'(1);
  assign full     = state != F_IDLE;
  assign cmd_push = (state == F_PUSH) && !cmd_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: begin
        if (push) begin
          state_next = (request.op == OP_ALLOCATE) ? F_PUSH : F_DIV;
        end
      end
      F_DIV: begin
        if (last) begin
          state_next = invalid_w ? F_PUSH : F_MOD;
        end
      end
      F_MOD: begin
        if (last) begin
          state_next = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!cmd_full) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (push) begin
          cmd.alloc       <= request.op == OP_ALLOCATE;
          cmd.invalid     <= 1'b0;
          cmd.page_index  <= '0;
          cmd.page_offset <= '0;
          cmd.victim      <= '0;
          quo             <= request.virt_addr;
          rem             <= '0;
          cnt             <= CNT_W'(DIV_CYCLES);
        end
      end
      F_DIV: begin
        quo <= q_w;
        rem <= r_w;
        if (last) begin
          cmd.page_index  <= q_w[IDX_W-1:0];
          cmd.page_offset <= r_w;
          cmd.invalid     <= invalid_w;
          // a valid page is below the page count, so it fits in PC_W bits
          mod_q           <= q_w[PC_W-1:0];
          mod_rem         <= '0;
          cnt             <= CNT_W'(PC_W);
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
      F_MOD: begin
        mod_q   <= mq_w;
        mod_rem <= mr_w;
        cnt     <= cnt - 1'b1;
        if (last) begin
          cmd.victim <= mr_w;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/pat_queue.sv @@
// ----------------------------------------------------------------------------
// pat_queue
// Two entry queue between front and back.
// ----------------------------------------------------------------------------
module pat_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  pat_pkg::pat_cmd_t wdata,
  output logic             full,
  input  logic             rd,
  output pat_pkg::pat_cmd_t rdata,
  output logic             empty
);
  import pat_pkg::*;

  localparam int DEPTH = 2;
  localparam int AW    = $clog2(DEPTH);

  pat_cmd_t        entries [DEPTH];
  logic [AW-1:0]   wptr;
  logic [AW-1:0]   rptr;
  logic [AW:0]     count;

  assign full  = count == (AW + 1)'(DEPTH);
  assign empty = count == '0;
  assign rdata = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr && !full) begin
        wptr <= wptr + 1'b1;
      end
      if (rd && !empty) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (AW + 1)'(wr && !full) - (AW + 1)'(rd && !empty);
    end
  end

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      entries[wptr] <= wdata;
    end
  end

endmodule

@@ rtl/pat_back.sv @@
// ----------------------------------------------------------------------------
// pat_back
// Carries out classified requests: page table and frame owner lookup and
// update, physical address scaling, and the result register.
// ----------------------------------------------------------------------------
module pat_back #(
  parameter int PAGE_SLOTS  = 64,
  parameter int FRAME_SLOTS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  pat_pkg::pat_cfg_t cfg,
  input  logic             q_empty,
  output logic             q_pop,
  input  pat_pkg::pat_cmd_t cmd,
  input  logic             pop,
  output logic             empty,
  output pat_pkg::pat_res_t result
);
  import pat_pkg::*;

  localparam int PAGE_AW  = $clog2(PAGE_SLOTS);
  localparam int FRAME_AW = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam int MUL_W    = FRAME_AW + PB_W;
  localparam int SUM_W    = (MUL_W + 1 > PHYS_W) ? MUL_W + 1 : PHYS_W;

  back_state_t state, state_next;

  // mapped and used flags, plus "identity" flags for entries set by allocate,
  // which saves sweeping the memories
  logic [PAGE_SLOTS-1:0]  page_mapped;
  logic [PAGE_SLOTS-1:0]  page_ident;
  logic [FRAME_SLOTS-1:0] frame_used;
  logic [FRAME_SLOTS-1:0] frame_ident;

  logic [FRAME_AW-1:0] page_frame_mem  [PAGE_SLOTS];
  logic [PAGE_AW-1:0]  frame_owner_mem [FRAME_SLOTS];
  logic [FRAME_AW-1:0] pf_rd;
  logic [PAGE_AW-1:0]  fo_rd;

  pat_cmd_t            cur;
  logic [FRAME_AW-1:0] frame_reg;
  status_t             status_reg;
  pat_res_t            res;
  logic                res_valid;

  logic [PAGE_AW-1:0]  hd_page;
  logic [FRAME_AW-1:0] hd_frame;
  logic [PAGE_AW-1:0]  p;
  logic [FRAME_AW-1:0] f;
  logic                hit;
  logic [FRAME_AW-1:0] hit_frame;
  logic [PAGE_AW-1:0]  old_page;
  logic                tbl_write;
  logic [PC_W-1:0]     alloc_n;
  logic [SUM_W-1:0]    phys_sum;

  assign hd_page   = PAGE_AW'(cmd.page_index[PC_W-1:0]);
  assign hd_frame  = FRAME_AW'(cmd.victim);
  assign p         = PAGE_AW'(cur.page_index[PC_W-1:0]);
  assign f         = FRAME_AW'(cur.victim);
  assign hit       = page_mapped[p];
  assign hit_frame = page_ident[p] ? FRAME_AW'(p) : pf_rd;
  assign old_page  = frame_ident[f] ? PAGE_AW'(f) : fo_rd;
  assign tbl_write = (state == B_LOOK) && !cur.alloc && !cur.invalid && !hit;
  assign alloc_n   = (cfg.page_count < {1'b0, cfg.frame_count}) ?
                     cfg.page_count : {1'b0, cfg.frame_count};
  assign phys_sum  = SUM_W'(frame_reg) * SUM_W'(cfg.page_bytes) + SUM_W'(cur.page_offset);

  assign q_pop  = (state == B_IDLE) && !q_empty && !res_valid;
  assign empty  = !res_valid;
  assign result = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (q_pop) begin
          state_next = B_LOOK;
        end
      end
      B_LOOK: state_next = (cur.alloc || cur.invalid) ? B_IDLE : B_MUL;
      B_MUL:  state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // tables; read address is the queue head, used the cycle after the pop
  always_ff @(posedge clk) begin
    if (tbl_write) begin
      page_frame_mem[p]  <= f;
      frame_owner_mem[f] <= p;
    end
    pf_rd <= page_frame_mem[hd_page];
    fo_rd <= frame_owner_mem[hd_frame];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page_mapped <= '0;
      page_ident  <= '0;
      frame_used  <= '0;
      frame_ident <= '0;
    end else if (state == B_LOOK && cur.alloc) begin
      for (int i = 0; i < PAGE_SLOTS; i++) begin
        page_mapped[i] <= i < int'(alloc_n);
        page_ident[i]  <= i < int'(alloc_n);
      end
      for (int j = 0; j < FRAME_SLOTS; j++) begin
        frame_used[j]  <= j < int'(alloc_n);
        frame_ident[j] <= j < int'(alloc_n);
      end
    end else if (tbl_write) begin
      // evict previous owner first; the new page's set below takes priority
      if (frame_used[f]) begin
        page_mapped[old_page] <= 1'b0;
      end
      page_mapped[p] <= 1'b1;
      page_ident[p]  <= 1'b0;
      frame_used[f]  <= 1'b1;
      frame_ident[f] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == B_LOOK && (cur.alloc || cur.invalid)) begin
      res_valid <= 1'b1;
    end else if (state == B_MUL) begin
      res_valid <= 1'b1;
    end else if (pop && res_valid) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= cmd;
    end
    if (state == B_LOOK) begin
      frame_reg  <= hit ? hit_frame : f;
      status_reg <= hit ? ST_HIT : ST_FAULT;
      if (cur.alloc) begin
        res.status      <= ST_ALLOC;
        res.page_index  <= '0;
        res.page_offset <= '0;
        res.frame_no    <= '0;
        res.phys_addr   <= '0;
      end else if (cur.invalid) begin
        res.status      <= ST_INVALID;
        res.page_index  <= cur.page_index;
        res.page_offset <= cur.page_offset[OFF_W-1:0];
        res.frame_no    <= '0;
        res.phys_addr   <= '0;
      end
    end
    if (state == B_MUL) begin
      res.status      <= status_reg;
      res.page_index  <= cur.page_index;
      res.page_offset <= cur.page_offset[OFF_W-1:0];
      res.frame_no    <= FRAME_OUT_W'(frame_reg);
      res.phys_addr   <= phys_sum[PHYS_W-1:0];
    end
  end

endmodule

@@ rtl/paged_address_translator_unit.sv @@
// ----------------------------------------------------------------------------
// paged_address_translator_unit
// Paged address translator: page table, frame owner table and address split.
// ----------------------------------------------------------------------------
// A translate request passes through the front end in these steps: accept,
// a two bit per cycle divide by the page size, a one bit per cycle page mod
// frame count, hand-off; one that falls outside the page count skips the
// mod, and an allocate request goes from accept straight to hand-off. The
// front divider sets the sustained rate. A two entry queue separates it from
// the back end, which does the table lookup and update and the frame times
// page size scaling, so requests keep being accepted while a result waits
// to be popped, until the queue fills. No clearing pass is needed after
// reset.
module paged_address_translator_unit #(
  parameter int PAGE_SLOTS     = 64,
  parameter int FRAME_SLOTS    = 32,
  parameter int MAX_PAGE_BYTES = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  pat_pkg::pat_req_t                   request,
  input  logic                                pop,
  output logic                                empty,
  output pat_pkg::pat_res_t                   result,
  input  logic                                cfg_write,
  input  logic [pat_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pat_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import pat_pkg::*;

  logic [PC_W-1:0] page_count;
  logic [FC_W-1:0] frame_count;
  logic [PB_W-1:0] page_bytes;
  pat_cfg_t        cfg;

  logic     cmd_push;
  pat_cmd_t cmd_in;
  logic     cmd_full;
  logic     cmd_pop;
  pat_cmd_t cmd_head;
  logic     cmd_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_count  <= PC_W'(64);
      frame_count <= FC_W'(32);
      page_bytes  <= PB_W'(4096);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PAGE_COUNT:  page_count  <= cfg_data[PC_W-1:0];
        REG_FRAME_COUNT: frame_count <= cfg_data[FC_W-1:0];
        REG_PAGE_BYTES:  page_bytes  <= cfg_data[PB_W-1:0];
        default: ;
      endcase
    end
  end

  // saturate to the supported ranges
  always_comb begin
    cfg.page_count  = page_count;
    cfg.frame_count = frame_count;
    cfg.page_bytes  = page_bytes;
    if (page_count == '0) begin
      cfg.page_count = PC_W'(1);
    end else if (int'(page_count) > PAGE_SLOTS) begin
      cfg.page_count = PC_W'(PAGE_SLOTS);
    end
    if (frame_count == '0) begin
      cfg.frame_count = FC_W'(1);
    end else if (int'(frame_count) > FRAME_SLOTS) begin
      cfg.frame_count = FC_W'(FRAME_SLOTS);
    end
    if (page_bytes == '0) begin
      cfg.page_bytes = PB_W'(1);
    end else if (int'(page_bytes) > MAX_PAGE_BYTES) begin
      cfg.page_bytes = PB_W'(MAX_PAGE_BYTES);
    end
  end

  pat_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .request  (request),
    .cfg      (cfg),
    .cmd_push (cmd_push),
    .cmd      (cmd_in),
    .cmd_full (cmd_full)
  );

  pat_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .rd    (cmd_pop),
    .rdata (cmd_head),
    .empty (cmd_empty)
  );

  pat_back #(
    .PAGE_SLOTS  (PAGE_SLOTS),
    .FRAME_SLOTS (FRAME_SLOTS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (cmd_empty),
    .q_pop   (cmd_pop),
    .cmd     (cmd_head),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

@@ rtl/pat_checker.sv @@
// ----------------------------------------------------------------------------
// pat_checker
// Port level checks for the paged address translator, bound to the top.
// ----------------------------------------------------------------------------
module pat_checker (
  input logic              clk,
  input logic              rst,
  input logic              pop,
  input logic              empty,
  input pat_pkg::pat_res_t result
);
  import pat_pkg::*;

  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_alloc_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status == ST_ALLOC) |->
      (result.page_index == '0 && result.page_offset == '0 &&
       result.frame_no == '0 && result.phys_addr == '0))
    else $error("allocate result carries non-zero fields");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status == ST_INVALID) |->
      (result.frame_no == '0 && result.phys_addr == '0))
    else $error("invalid result carries a frame or address");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed before pop");

endmodule

bind paged_address_translator_unit pat_checker u_pat_checker (.*);

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for paged_address_translator_unit. A short table of
// directed requests is run first, then phases of random requests under
// several page, frame and page size settings. Expected results come from
// known table rows or an in-bench page table model, checked field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import pat_pkg::*;

  localparam int PAGE_SLOTS     = 64;
  localparam int FRAME_SLOTS    = 32;
  localparam int MAX_PAGE_BYTES = 4096;
  localparam int ADDR_MAX       = (1 << ADDR_W) - 1;
  localparam int DIR_ROWS       = 32;
  localparam int PHASES         = 12;
  localparam int PHASE_REQUESTS = 162;

  // no register sits at this index
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_ITEM_KNOWN,
    ROW_WRITE
  } row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] reg_data;
    pat_req_t              req;
    pat_res_t              known;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  push = 1'b0;
  logic                  full;
  pat_req_t              request = '0;
  logic                  pop = 1'b0;
  logic                  empty;
  pat_res_t              result;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // translator model: registers as written, clamped values, tables
  logic [PC_W-1:0]        page_count_reg = 7'd64;
  logic [FC_W-1:0]        frame_count_reg = 6'd32;
  logic [PB_W-1:0]        page_bytes_reg = 13'd4096;
  int                     pages_in_use = PAGE_SLOTS;
  int                     frames_in_use = FRAME_SLOTS;
  int                     bytes_per_page = MAX_PAGE_BYTES;
  logic [FRAME_OUT_W-1:0] page_frame [PAGE_SLOTS];
  logic                   page_mapped [PAGE_SLOTS];
  logic [FC_W-1:0]        frame_owner [FRAME_SLOTS];
  logic                   frame_used [FRAME_SLOTS];

  pat_res_t pending_results [$];
  pat_res_t want;
  int       mismatches = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;

  stim_row_t directed_rows [DIR_ROWS] = '{
    // empty tables after reset, default sizes
    '{ROW_ITEM_KNOWN, REG_PAGE_COUNT, 13'd0, '{OP_TRANSLATE, 18'd0},
      '{ST_FAULT, 12'd0, 12'd0, 5'd0, 17'd0}},
    '{ROW_ITEM_KNOWN, REG_PAGE_COUNT, 13'd0, '{OP_TRANSLATE, 18'h3FFFF},
      '{ST_FAULT, 12'd63, 12'd4095, 5'd31, 17'h1FFFF}},
    '{ROW_ITEM_KNOWN, REG_PAGE_COUNT, 13'd0, '{OP_TRANSLATE, 18'd0},
      '{ST_HIT, 12'd0, 12'd0, 5'd0, 17'd0}},
    // page 31 takes frame 31 from page 63, then the reverse
    '{ROW_ITEM, REG_PAGE_COUNT, 13'd0, '{OP_TRANSLATE, 18'd126976}, '0},
    '{ROW_ITEM, REG_PAGE_COUNT, 13'd0, '{OP_TRANSLATE, 18'h3FFFF}, '0},
    '{ROW_ITEM_KNOWN, REG_PAGE_COUNT, 13'd0, '{OP_ALLOCATE, 18'h3FFFF},
      '{ST_ALLOC, 12'd0, 12'd0, 5'd0, 17'd0}},
    '{ROW_ITEM, REG_PAGE_COUNT, 13'd0, '{OP_TRANSLATE, 18'd20487}, '0},
    '{ROW_ITEM, REG_PAGE_COUNT, 13'd0, '{OP_TRANSLATE, 18'd163940}, '0},
    '{ROW_ITEM, REG_PAGE_COUNT, 13'd0, '{OP_TRANSLATE, 18'd32768}, '0},
    // page count of zero behaves as one
    '{ROW_WRITE, REG_PAGE_COUNT, 13'd0, '0, '0},
    '{ROW_ITEM_KNOWN, REG_PAGE_COUNT, 13'd0, '{OP_TRANSLATE, 18'd4096},
      '{ST_INVALID, 12'd1, 12'd0, 5'd0, 17'd0}},
    '{ROW_ITEM_KNOWN, REG_PAGE_COUNT, 13'd0, '{OP_TRANSLATE, 18'd0},
      '{ST_HIT, 12'd0, 12'd0, 5'd0, 17'd0}},
    '{ROW_ITEM_KNOWN, REG_PAGE_COUNT, 13'd0, '{OP_TRANSLATE, 18'h3FFFF},
      '{ST_INVALID, 12'd63, 12'd4095, 5'd0, 17'd0}},
    // over-range and zero values saturate; upper data bits dropped
    '{ROW_WRITE, REG_PAGE_COUNT, 13'h1FFF, '0, '0},
    '{ROW_WRITE, REG_FRAME_COUNT, 13'h1FC0, '0, '0},
    '{ROW_WRITE, REG_PAGE_BYTES, 13'd0, '0, '0},
    '{ROW_ITEM_KNOWN, REG_PAGE_COUNT, 13'd0, '{OP_TRANSLATE, 18'h3FFFF},
      '{ST_INVALID, 12'hFFF, 12'd0, 5'd0, 17'd0}},
    '{ROW_ITEM, REG_PAGE_COUNT, 13'd0, '{OP_TRANSLATE, 18'd63}, '0},
    '{ROW_ITEM_KNOWN, REG_PAGE_COUNT, 13'd0, '{OP_ALLOCATE, 18'd0},
      '{ST_ALLOC, 12'd0, 12'd0, 5'd0, 17'd0}},
    '{ROW_ITEM_KNOWN, REG_PAGE_COUNT, 13'd0, '{OP_TRANSLATE, 18'd0},
      '{ST_HIT, 12'd0, 12'd0, 5'd0, 17'd0}},
    '{ROW_ITEM, REG_PAGE_COUNT, 13'd0, '{OP_TRANSLATE, 18'd1}, '0},
    '{ROW_WRITE, REG_FRAME_COUNT, 13'd63, '0, '0},
    '{ROW_WRITE, REG_PAGE_BYTES, 13'h1FFF, '0, '0},
    '{ROW_ITEM_KNOWN, REG_PAGE_COUNT, 13'd0, '{OP_ALLOCATE, 18'd12345},
      '{ST_ALLOC, 12'd0, 12'd0, 5'd0, 17'd0}},
    // shrink frame count with pages already mapped above it
    '{ROW_WRITE, REG_FRAME_COUNT, 13'd4, '0, '0},
    '{ROW_ITEM, REG_PAGE_COUNT, 13'd0, '{OP_TRANSLATE, 18'd86015}, '0},
    '{ROW_ITEM, REG_PAGE_COUNT, 13'd0, '{OP_TRANSLATE, 18'd163840}, '0},
    '{ROW_ITEM, REG_PAGE_COUNT, 13'd0, '{OP_TRANSLATE, 18'd0}, '0},
    '{ROW_WRITE, REG_UNUSED, 13'h1FFF, '0, '0},
    '{ROW_WRITE, REG_PAGE_BYTES, 13'd3000, '0, '0},
    '{ROW_ITEM, REG_PAGE_COUNT, 13'd0, '{OP_TRANSLATE, 18'h3FFFF}, '0},
    '{ROW_ITEM, REG_PAGE_COUNT, 13'd0, '{OP_TRANSLATE, 18'd12345}, '0}
  };

  paged_address_translator_unit #(
    .PAGE_SLOTS    (PAGE_SLOTS),
    .FRAME_SLOTS   (FRAME_SLOTS),
    .MAX_PAGE_BYTES(MAX_PAGE_BYTES)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .request  (request),
    .pop      (pop),
    .empty    (empty),
    .result   (result),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("** paged_address_translator_unit: FAILED **");
    $finish;
  end

  function automatic void clear_tables();
    for (int i = 0; i < PAGE_SLOTS; i++) begin
      page_frame[i]  = '0;
      page_mapped[i] = 1'b0;
    end
    for (int i = 0; i < FRAME_SLOTS; i++) begin
      frame_owner[i] = '0;
      frame_used[i]  = 1'b0;
    end
  endfunction

  // result of one request; updates the page and frame tables
  function automatic pat_res_t translate_request(pat_req_t req);
    pat_res_t res;
    int       page;
    int       offset;
    int       frame;
    res = '0;
    if (req.op == OP_ALLOCATE) begin
      clear_tables();
      for (int i = 0; i < pages_in_use && i < frames_in_use; i++) begin
        page_frame[i]  = FRAME_OUT_W'(i);
        page_mapped[i] = 1'b1;
        frame_owner[i] = FC_W'(i);
        frame_used[i]  = 1'b1;
      end
      res.status = ST_ALLOC;
      return res;
    end
    page   = int'(req.virt_addr) / bytes_per_page;
    offset = int'(req.virt_addr) % bytes_per_page;
    res.page_index  = page[IDX_W-1:0];
    res.page_offset = offset[OFF_W-1:0];
    if (page >= pages_in_use) begin
      res.status = ST_INVALID;
    end else begin
      if (page_mapped[page]) begin
        res.status = ST_HIT;
      end else begin
        frame = page % frames_in_use;
        // evict whoever held the frame
        if (frame_used[frame]) page_mapped[frame_owner[frame]] = 1'b0;
        frame_owner[frame] = FC_W'(page);
        frame_used[frame]  = 1'b1;
        page_frame[page]   = FRAME_OUT_W'(frame);
        page_mapped[page]  = 1'b1;
        res.status = ST_FAULT;
      end
      res.frame_no  = page_frame[page];
      res.phys_addr = PHYS_W'(int'(page_frame[page]) * bytes_per_page + offset);
    end
    return res;
  endfunction

  // registers only change once the unit has drained
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_PAGE_COUNT:  page_count_reg  = data[PC_W-1:0];
      REG_FRAME_COUNT: frame_count_reg = data[FC_W-1:0];
      REG_PAGE_BYTES:  page_bytes_reg  = data[PB_W-1:0];
      default: ;
    endcase
    pages_in_use   = (page_count_reg == 0) ? 1 :
                     (page_count_reg > PAGE_SLOTS) ? PAGE_SLOTS : page_count_reg;
    frames_in_use  = (frame_count_reg == 0) ? 1 :
                     (frame_count_reg > FRAME_SLOTS) ? FRAME_SLOTS : frame_count_reg;
    bytes_per_page = (page_bytes_reg == 0) ? 1 :
                     (page_bytes_reg > MAX_PAGE_BYTES) ? MAX_PAGE_BYTES : page_bytes_reg;
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // push stays high on return so back-to-back requests need not lower it in between
  task automatic issue_request(input pat_req_t req, input logic known,
                               input pat_res_t known_res);
    pat_res_t predicted;
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    push    <= 1'b1;
    request <= req;
    do @(posedge clk); while (full);
    predicted = translate_request(req);
    pending_results.push_back(known ? known_res : predicted);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          $error("result with no request waiting: %p", result);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (result.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result.status);
            mismatches++;
          end
          if (result.page_index !== want.page_index) begin
            $error("page_index: expected %0d, got %0d", want.page_index,
                   result.page_index);
            mismatches++;
          end
          if (result.page_offset !== want.page_offset) begin
            $error("page_offset: expected %0d, got %0d", want.page_offset,
                   result.page_offset);
            mismatches++;
          end
          if (result.frame_no !== want.frame_no) begin
            $error("frame_no: expected %0d, got %0d", want.frame_no,
                   result.frame_no);
            mismatches++;
          end
          if (result.phys_addr !== want.phys_addr) begin
            $error("phys_addr: expected %0d, got %0d",
                   want.phys_addr, result.phys_addr);
            mismatches++;
          end
        end
      end
      pop <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin
    pat_req_t req;
    int       pg;
    int       addr;
    int       pc_val;
    int       fc_val;
    int       pb_val;
    clear_tables();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int n = 0; n < DIR_ROWS; n++) begin
      if (directed_rows[n].kind == ROW_WRITE)
        write_register(directed_rows[n].reg_index, directed_rows[n].reg_data);
      else
        issue_request(directed_rows[n].req, directed_rows[n].kind == ROW_ITEM_KNOWN,
                      directed_rows[n].known);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      if (phase == 0) begin
        pc_val = PAGE_SLOTS; fc_val = FRAME_SLOTS; pb_val = MAX_PAGE_BYTES;
      end else if (phase == 1) begin
        pc_val = 1; fc_val = 1; pb_val = 1;
      end else begin
        pc_val = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                             : $urandom_range(1, PAGE_SLOTS);
        fc_val = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                             : $urandom_range(1, FRAME_SLOTS);
        case ($urandom_range(0, 3))
          0: pb_val = $urandom_range(0, 8191);
          1: pb_val = 1 << $urandom_range(0, 12);
          default: pb_val = $urandom_range(1, MAX_PAGE_BYTES);
        endcase
      end
      write_register(REG_PAGE_COUNT, CFG_DATA_W'(pc_val));
      write_register(REG_FRAME_COUNT, CFG_DATA_W'(fc_val));
      write_register(REG_PAGE_BYTES, CFG_DATA_W'(pb_val));

      for (int k = 0; k < PHASE_REQUESTS; k++) begin
        // mostly start a phase from a fresh allocation
        if ((k == 0 && $urandom_range(0, 3) != 0) || $urandom_range(0, 99) < 3) begin
          req.op = OP_ALLOCATE;
          req.virt_addr = ADDR_W'($urandom);
        end else begin
          req.op = OP_TRANSLATE;
          if ($urandom_range(0, 4) == 0) begin
            req.virt_addr = ADDR_W'($urandom);
          end else begin
            // page up to the count itself, so some land out of range
            pg   = $urandom_range(0, pages_in_use);
            addr = pg * bytes_per_page + $urandom_range(0, bytes_per_page - 1);
            req.virt_addr = (addr > ADDR_MAX) ? ADDR_W'($urandom) : ADDR_W'(addr);
          end
        end
        issue_request(req, 1'b0, '0);
      end
    end

    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("** paged_address_translator_unit: PASSED **");
    else
      $display("** paged_address_translator_unit: FAILED **");
    $finish;
  end

endmodule
